FILE: hdl/mwo_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and constant tables for the waveform oscillator.
// Depends on nothing; the design files refer to it by scoped names, the testbench imports it.
package mwo_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int MAX_HARMONICS   = 32;

    localparam int TIME_W   = 40;
    localparam int FREQ_W   = 24;
    localparam int PHASE_W  = 16;
    localparam int SAMPLE_W = 24;
    localparam int PROD_W   = 36;
    localparam int HALF_W   = PROD_W / 2;
    localparam int N_W      = (MAX_HARMONICS > 2) ? $clog2(MAX_HARMONICS) : 1;
    localparam int QLEN     = (1 << SINE_TABLE_BITS) + 1;
    localparam int ADDR_W   = SINE_TABLE_BITS + 1;
    localparam int ACC_W    = 35;
    localparam int W_W      = 22;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int FIFO_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQUENCY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HARMONICS = 3'd5;

    localparam logic [2:0] WAVE_SINE     = 3'd0;
    localparam logic [2:0] WAVE_SQUARE   = 3'd1;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd2;
    localparam logic [2:0] WAVE_SAW      = 3'd3;
    localparam logic [2:0] WAVE_INV_SAW  = 3'd4;
    localparam logic [2:0] WAVE_ADD_SAW  = 3'd5;

    localparam logic [29:0] TWO_OVER_PI_Q30 = 30'd683565276;
    localparam int SAMPLE_MAX = 8388607;
    localparam int SAMPLE_MIN = -8388608;

    localparam logic [63:0] PC1 = 64'd1686629713;
    localparam logic [63:0] PC3 = 64'd693598674;
    localparam logic [63:0] PC5 = 64'd85569306;
    localparam logic [63:0] PC7 = 64'd5026993;
    localparam logic [63:0] PC9 = 64'd172272;

    typedef struct packed {
        logic [2:0]          waveform;
        logic [14:0]         volume;
        logic [FREQ_W-1:0]   frequency_hz;
        logic [PHASE_W-1:0]  phase_offset;
        logic signed [15:0]  shape_threshold;
        logic [5:0]          harmonic_limit;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [PROD_W-1:0] prod;
    } t_prod_beat;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HI,
        F_SUM,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_RUN,
        B_KMUL,
        B_WAVE,
        B_VOL,
        B_OUT
    } t_back_state;

    typedef logic [14:0] t_qtab [QLEN];
    typedef logic [31:0] t_recip_tab [2**N_W];

    function automatic t_qtab build_qtab();
        t_qtab       tab;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] t;
        logic [63:0] y;
        for (int i = 0; i < QLEN; i++) begin
            x = 64'(i) << (30 - SINE_TABLE_BITS);
            s = (x * x) >> 30;
            t = PC9;
            t = PC7 - ((s * t) >> 30);
            t = PC5 - ((s * t) >> 30);
            t = PC3 - ((s * t) >> 30);
            t = PC1 - ((s * t) >> 30);
            y = (x * t) >> 30;
            y = (y + 64'd16384) >> 15;
            if (y > 64'd32767) begin
                y = 64'd32767;
            end
            tab[i] = y[14:0];
        end
        return tab;
    endfunction

    function automatic t_recip_tab build_recip();
        t_recip_tab  tab;
        logic [63:0] q;
        tab[0] = 32'd0;
        for (int i = 1; i < 2**N_W; i++) begin
            q = (64'd1 << 31) / 64'(i);
            tab[i] = q[31:0];
        end
        return tab;
    endfunction

endpackage

FILE: hdl/mwo_front.sv
`timescale 1ns / 1ps
// Front end: accepts time stamps and forms the cycle position product.
// Depends on mwo_pkg; feeds the product queue.
module mwo_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [mwo_pkg::TIME_W-1:0]  i_time_seconds,
    input  logic [mwo_pkg::FREQ_W-1:0]  i_frequency_hz,
    output mwo_pkg::t_prod_beat         o_push,
    input  logic                        i_push_ready
);

    localparam int HW    = mwo_pkg::HALF_W;
    localparam int PW    = mwo_pkg::PROD_W;
    localparam int MUL_W = mwo_pkg::FREQ_W + HW;

    mwo_pkg::t_front_state r_state;
    mwo_pkg::t_front_state n_state;

    logic [PW-1:0]    r_lo;
    logic [HW-1:0]    r_hi_t;
    logic [HW-1:0]    r_hi;
    logic [PW-1:0]    r_prod;
    logic [MUL_W-1:0] c_lo_full;
    logic [MUL_W-1:0] c_hi_full;
    logic             c_accept;

    assign c_lo_full = MUL_W'(i_frequency_hz) * MUL_W'(i_time_seconds[HW-1:0]);
    assign c_hi_full = MUL_W'(i_frequency_hz) * MUL_W'(r_hi_t);
    assign c_accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mwo_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_lo   <= c_lo_full[PW-1:0];
            r_hi_t <= i_time_seconds[PW-1:HW];
        end
        if (r_state == mwo_pkg::F_HI) begin
            r_hi <= c_hi_full[HW-1:0];
        end
        if (r_state == mwo_pkg::F_SUM) begin
            r_prod <= r_lo + {r_hi, {HW{1'b0}}};
        end
    end

    always_comb begin
        n_state     = r_state;
        o_ready     = 1'b0;
        o_push.valid = 1'b0;
        o_push.prod  = r_prod;
        case (r_state)
            mwo_pkg::F_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = mwo_pkg::F_HI;
                end
            end
            mwo_pkg::F_HI: begin
                n_state = mwo_pkg::F_SUM;
            end
            mwo_pkg::F_SUM: begin
                n_state = mwo_pkg::F_PUSH;
            end
            mwo_pkg::F_PUSH: begin
                o_push.valid = 1'b1;
                if (i_push_ready) begin
                    n_state = mwo_pkg::F_IDLE;
                end
            end
            default: begin
                n_state = mwo_pkg::F_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/mwo_fifo.sv
`timescale 1ns / 1ps
// Short queue of phase products between the front end and the back end.
// Depends on mwo_pkg.
module mwo_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mwo_pkg::t_prod_beat i_push,
    output logic                o_push_ready,
    output mwo_pkg::t_prod_beat o_pop,
    input  logic                i_pop_ready
);

    localparam int DEPTH = mwo_pkg::FIFO_DEPTH;
    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [mwo_pkg::PROD_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]           r_wr_ptr;
    logic [PTR_W-1:0]           r_rd_ptr;
    logic [CNT_W-1:0]           r_count;
    logic                       c_push;
    logic                       c_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop.valid  = (r_count != '0);
    assign o_pop.prod   = r_mem[r_rd_ptr];
    assign c_push       = i_push.valid && o_push_ready;
    assign c_pop        = o_pop.valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (c_push) begin
            r_mem[r_wr_ptr] <= i_push.prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (c_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (c_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (c_push && !c_pop) begin
                r_count <= r_count + 1'b1;
            end else if (c_pop && !c_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/mwo_back.sv
`timescale 1ns / 1ps
// Back end: harmonic pipeline through the quarter-wave table, reciprocal
// division, waveform selection, volume scaling and the output register.
// Depends on mwo_pkg.
module mwo_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mwo_pkg::t_cfg                 i_cfg,
    input  mwo_pkg::t_prod_beat           i_pop,
    output logic                          o_pop_ready,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [mwo_pkg::SAMPLE_W-1:0] o_sample
);

    localparam int B       = mwo_pkg::SINE_TABLE_BITS;
    localparam int AW      = mwo_pkg::ADDR_W;
    localparam int NW      = mwo_pkg::N_W;
    localparam int PW      = mwo_pkg::PROD_W;
    localparam int ACC_W   = mwo_pkg::ACC_W;
    localparam int W_W     = mwo_pkg::W_W;
    localparam int SH_W    = ACC_W - 15;
    localparam int KPROD_W = SH_W + 31;
    localparam int WV_W    = W_W + 16;
    localparam int S_W     = WV_W - 7;
    localparam int DIVP_W  = 62;
    localparam int QLEN_M1 = mwo_pkg::QLEN - 1;

    localparam mwo_pkg::t_qtab      QTAB  = mwo_pkg::build_qtab();
    localparam mwo_pkg::t_recip_tab RECIP = mwo_pkg::build_recip();

    localparam logic signed [W_W-1:0] W_POS = W_W'(32768);
    localparam logic signed [W_W-1:0] W_NEG = -W_W'(32768);
    localparam logic signed [S_W-1:0] S_MAX = S_W'(mwo_pkg::SAMPLE_MAX);
    localparam logic signed [S_W-1:0] S_MIN = S_W'(mwo_pkg::SAMPLE_MIN);

    mwo_pkg::t_back_state r_state;
    mwo_pkg::t_back_state n_state;

    logic [PW-1:0] r_base;
    logic [PW-1:0] r_pn;
    logic [NW-1:0] r_n;
    logic [NW-1:0] r_left;

    logic          r_s1_valid;
    logic [AW-1:0] r_s1_addr;
    logic          r_s1_neg;
    logic [31:0]   r_s1_p;
    logic [NW-1:0] r_s1_n;

    logic [14:0]   r_rom;
    logic          r_s2_valid;
    logic          r_s2_neg;
    logic [31:0]   r_s2_p;
    logic [NW-1:0] r_s2_n;

    logic signed [16:0] r_sine;
    logic [31:0]        r_phase;

    logic              r_s3_valid;
    logic [DIVP_W-1:0] r_s3_prod;
    logic [29:0]       r_s3_a;
    logic [NW-1:0]     r_s3_n;
    logic              r_s3_neg;

    logic          r_s4_valid;
    logic [29:0]   r_s4_q0;
    logic [29:0]   r_s4_qn;
    logic [29:0]   r_s4_a;
    logic [NW-1:0] r_s4_n;
    logic          r_s4_neg;

    logic              r_s5_valid;
    logic signed [30:0] r_s5_q;

    logic signed [ACC_W-1:0]   r_acc;
    logic signed [KPROD_W-1:0] r_kprod;
    logic signed [W_W-1:0]     r_w;
    logic signed [WV_W-1:0]    r_wv;
    logic                      r_out_valid;
    logic signed [mwo_pkg::SAMPLE_W-1:0] r_out_sample;

    logic          c_pop;
    logic          c_issue;
    logic          c_drained;
    logic          c_out_write;
    logic [7:0]    c_lim;
    logic [NW-1:0] c_count;
    logic [31:0]   c_p0;
    logic [B-1:0]  c_idx;
    logic [AW-1:0] c_addr;
    logic signed [16:0] c_sine;
    logic [29:0]   c_a2;
    logic [29:0]   c_q0;
    logic [29:0]   c_r;
    logic [29:0]   c_q;
    logic signed [SH_W-1:0]  c_acc_sh;
    logic signed [W_W-1:0]   c_wadd;
    logic signed [W_W-1:0]   c_tri_r;
    logic signed [W_W-1:0]   c_saw;
    logic signed [W_W-1:0]   c_wave;
    logic signed [S_W-1:0]   c_s;
    logic signed [mwo_pkg::SAMPLE_W-1:0] c_sat;

    // Harmonic count: one for plain waves, limit-1 clamped to 0..31 for additive saw.
    always_comb begin
        c_lim = ({2'b00, i_cfg.harmonic_limit} > 8'(mwo_pkg::MAX_HARMONICS))
              ? 8'(mwo_pkg::MAX_HARMONICS) : {2'b00, i_cfg.harmonic_limit};
        if (i_cfg.waveform == mwo_pkg::WAVE_ADD_SAW) begin
            c_count = (c_lim >= 8'd2) ? NW'(c_lim - 8'd1) : '0;
        end else begin
            c_count = NW'(1);
        end
    end

    assign c_p0   = r_pn[PW-1:4] + {i_cfg.phase_offset, 16'b0};
    assign c_idx  = c_p0[29 -: B];
    assign c_addr = c_p0[30] ? (AW'(QLEN_M1) - {1'b0, c_idx}) : {1'b0, c_idx};

    assign c_sine = r_s2_neg ? -$signed({2'b00, r_rom}) : $signed({2'b00, r_rom});
    assign c_a2   = {r_rom, 15'b0};
    assign c_q0   = r_s3_prod[60:31];
    assign c_r    = r_s4_a - r_s4_qn;
    assign c_q    = (c_r >= 30'(r_s4_n)) ? r_s4_q0 + 30'd1 : r_s4_q0;

    assign c_acc_sh = $signed(r_acc[ACC_W-1:15]);
    assign c_wadd   = W_W'($signed(r_kprod[KPROD_W-1:30]));
    assign c_tri_r  = $signed({{(W_W-15){1'b0}}, r_phase[29:15]});
    assign c_saw    = $signed({{(W_W-16){1'b0}}, r_phase[31:16]}) - W_POS;

    always_comb begin
        case (r_phase[31:30])
            2'd0:    c_wave = c_tri_r;
            2'd1:    c_wave = W_POS - c_tri_r;
            2'd2:    c_wave = -c_tri_r;
            default: c_wave = c_tri_r - W_POS;
        endcase
    end

    assign c_s   = $signed(r_wv[WV_W-1:7]);
    assign c_sat = (c_s > S_MAX) ? mwo_pkg::SAMPLE_W'(S_MAX)
                 : (c_s < S_MIN) ? mwo_pkg::SAMPLE_W'(S_MIN)
                 : c_s[mwo_pkg::SAMPLE_W-1:0];

    assign c_drained = !r_s1_valid && !r_s2_valid && !r_s3_valid && !r_s4_valid
                     && !r_s5_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mwo_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        c_pop       = 1'b0;
        c_issue     = 1'b0;
        c_out_write = 1'b0;
        case (r_state)
            mwo_pkg::B_IDLE: begin
                if (i_pop.valid) begin
                    c_pop   = 1'b1;
                    n_state = mwo_pkg::B_RUN;
                end
            end
            mwo_pkg::B_RUN: begin
                c_issue = (r_left != '0);
                if (!c_issue && c_drained) begin
                    n_state = mwo_pkg::B_KMUL;
                end
            end
            mwo_pkg::B_KMUL: begin
                n_state = mwo_pkg::B_WAVE;
            end
            mwo_pkg::B_WAVE: begin
                n_state = mwo_pkg::B_VOL;
            end
            mwo_pkg::B_VOL: begin
                n_state = mwo_pkg::B_OUT;
            end
            mwo_pkg::B_OUT: begin
                if (!r_out_valid || i_ready) begin
                    c_out_write = 1'b1;
                    n_state     = mwo_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = mwo_pkg::B_IDLE;
            end
        endcase
    end

    assign o_pop_ready = c_pop;

    // Remaining-harmonic count, pipeline valids and the output flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (c_pop) begin
                r_left <= c_count;
            end else if (c_issue) begin
                r_left <= r_left - 1'b1;
            end
            r_s1_valid <= c_issue;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
            if (c_out_write) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_pop) begin
            r_base <= i_pop.prod;
            r_pn   <= i_pop.prod;
            r_n    <= NW'(1);
            r_acc  <= '0;
        end else begin
            if (c_issue) begin
                r_pn <= r_pn + r_base;
                r_n  <= r_n + 1'b1;
            end
            if (r_s5_valid) begin
                r_acc <= r_acc + ACC_W'(r_s5_q);
            end
        end

        r_s1_addr <= c_addr;
        r_s1_neg  <= c_p0[31];
        r_s1_p    <= c_p0;
        r_s1_n    <= r_n;

        r_rom    <= QTAB[r_s1_addr];
        r_s2_neg <= r_s1_neg;
        r_s2_p   <= r_s1_p;
        r_s2_n   <= r_s1_n;

        if (r_s2_valid) begin
            r_sine  <= c_sine;
            r_phase <= r_s2_p;
        end
        r_s3_prod <= DIVP_W'(c_a2) * DIVP_W'(RECIP[r_s2_n]);
        r_s3_a    <= c_a2;
        r_s3_n    <= r_s2_n;
        r_s3_neg  <= r_s2_neg;

        r_s4_q0  <= c_q0;
        r_s4_qn  <= 30'(c_q0 * 30'(r_s3_n));
        r_s4_a   <= r_s3_a;
        r_s4_n   <= r_s3_n;
        r_s4_neg <= r_s3_neg;

        r_s5_q <= r_s4_neg ? -$signed({1'b0, c_q}) : $signed({1'b0, c_q});

        if (r_state == mwo_pkg::B_KMUL) begin
            r_kprod <= KPROD_W'(c_acc_sh) * KPROD_W'($signed({1'b0, mwo_pkg::TWO_OVER_PI_Q30}));
        end

        if (r_state == mwo_pkg::B_WAVE) begin
            case (i_cfg.waveform)
                mwo_pkg::WAVE_SINE: begin
                    r_w <= W_W'(r_sine);
                end
                mwo_pkg::WAVE_SQUARE: begin
                    r_w <= (r_sine > 17'(i_cfg.shape_threshold)) ? W_POS : W_NEG;
                end
                mwo_pkg::WAVE_TRIANGLE: begin
                    r_w <= c_wave;
                end
                mwo_pkg::WAVE_SAW: begin
                    r_w <= (i_cfg.frequency_hz == '0) ? '0 : c_saw;
                end
                mwo_pkg::WAVE_INV_SAW: begin
                    r_w <= (i_cfg.frequency_hz == '0) ? '0 : -c_saw;
                end
                mwo_pkg::WAVE_ADD_SAW: begin
                    r_w <= c_wadd;
                end
                default: begin
                    r_w <= '0;
                end
            endcase
        end

        if (r_state == mwo_pkg::B_VOL) begin
            r_wv <= WV_W'(r_w) * WV_W'($signed({1'b0, i_cfg.volume}));
        end

        if (c_out_write) begin
            r_out_sample <= c_sat;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_sample = r_out_sample;

endmodule

FILE: hdl/multi_waveform_oscillator.sv
`timescale 1ns / 1ps
// The back end takes a queued beat only after it has finished the last one; its harmonic
// pipeline issues one harmonic a cycle through the sine table. The front end and the queue
// meanwhile keep accepting time stamps until a full queue holds back the front end's product.
// Reset clears the queue, both sequencers and the output valid flag and loads the register
// defaults; the sine and reciprocal tables are constant, so no clearing pass is needed.
module multi_waveform_oscillator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [mwo_pkg::TIME_W-1:0]            i_time_seconds,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [mwo_pkg::SAMPLE_W-1:0]   o_sample,
    input  logic                                  i_cfg_we,
    input  logic [mwo_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [mwo_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    mwo_pkg::t_cfg       r_cfg;
    mwo_pkg::t_prod_beat c_push;
    mwo_pkg::t_prod_beat c_pop;
    logic                c_push_ready;
    logic                c_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.waveform        <= mwo_pkg::WAVE_SINE;
            r_cfg.volume          <= 15'd16384;
            r_cfg.frequency_hz    <= 24'd1802240;
            r_cfg.phase_offset    <= 16'd0;
            r_cfg.shape_threshold <= 16'sd0;
            r_cfg.harmonic_limit  <= 6'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mwo_pkg::CFG_WAVEFORM:  r_cfg.waveform        <= i_cfg_data[2:0];
                mwo_pkg::CFG_VOLUME:    r_cfg.volume          <= i_cfg_data[14:0];
                mwo_pkg::CFG_FREQUENCY: r_cfg.frequency_hz    <= i_cfg_data[23:0];
                mwo_pkg::CFG_PHASE:     r_cfg.phase_offset    <= i_cfg_data[15:0];
                mwo_pkg::CFG_THRESHOLD: r_cfg.shape_threshold <= $signed(i_cfg_data[15:0]);
                mwo_pkg::CFG_HARMONICS: r_cfg.harmonic_limit  <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    mwo_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_time_seconds (i_time_seconds),
        .i_frequency_hz (r_cfg.frequency_hz),
        .o_push         (c_push),
        .i_push_ready   (c_push_ready)
    );

    mwo_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (c_push),
        .o_push_ready (c_push_ready),
        .o_pop        (c_pop),
        .i_pop_ready  (c_pop_ready)
    );

    mwo_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pop       (c_pop),
        .o_pop_ready (c_pop_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_sample    (o_sample)
    );

endmodule

FILE: hdl/mwo_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the waveform oscillator, bound to the top level.
// Depends on mwo_pkg and multi_waveform_oscillator.
module mwo_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic                                  o_ready,
    input  logic                                  o_valid,
    input  logic                                  i_ready,
    input  logic signed [mwo_pkg::SAMPLE_W-1:0]   o_sample,
    input  logic                                  i_cfg_we
);

    localparam logic [2:0] CAPACITY = 3'd5;

    logic [2:0] r_pending;
    logic       c_in_beat;
    logic       c_out_beat;

    assign c_in_beat  = i_valid && o_ready;
    assign c_out_beat = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (c_in_beat && !c_out_beat) begin
            r_pending <= r_pending + 1'b1;
        end else if (c_out_beat && !c_in_beat) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample))
        else $error("stalled result beat changed");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_pending != 3'd0)
        else $error("result beat without an accepted item");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= CAPACITY)
        else $error("more items in flight than the block can hold");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> r_pending == 3'd0)
        else $error("register write while items are in flight");

endmodule

bind multi_waveform_oscillator mwo_checker u_checker (.*);

FILE: verif/multi_waveform_oscillator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for multi_waveform_oscillator: time stamps in, one sample out per beat.
// Depends on mwo_pkg and the block; predicts each sample from a shadow copy of the registers.
module multi_waveform_oscillator_tb;

    import mwo_pkg::*;

    typedef struct packed {
        logic [2:0]         waveform;
        logic [14:0]        volume;
        logic [FREQ_W-1:0]  frequency_hz;
        logic [PHASE_W-1:0] phase_offset;
        logic signed [15:0] shape_threshold;
        logic [5:0]         harmonic_limit;
    } osc_settings_t;

    localparam logic [2:0] WAVE_SPARE_LO = 3'd6;
    localparam logic [2:0] WAVE_SPARE_HI = 3'd7;

    localparam osc_settings_t RESET_SETTINGS = '{
        waveform:        WAVE_SINE,
        volume:          15'd16384,
        frequency_hz:    24'd1802240,
        phase_offset:    16'd0,
        shape_threshold: 16'sd0,
        harmonic_limit:  6'd16
    };

    localparam longint FULL_SCALE       = 32768;
    localparam int     SETTLE_CYCLES    = 96;
    localparam int     LONG_HOLD_CYCLES = 300;
    localparam int     WATCHDOG_LIMIT   = 4000;

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       i_valid        = 1'b0;
    logic                       o_ready;
    logic [TIME_W-1:0]          i_time_seconds = '0;
    logic                       o_valid;
    logic                       i_ready        = 1'b0;
    logic signed [SAMPLE_W-1:0] o_sample;
    logic                       i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data     = '0;

    int                         quarter_sine [QLEN];
    osc_settings_t              settings = RESET_SETTINGS;
    logic signed [SAMPLE_W-1:0] expected_samples [$];

    bit tx_gaps           = 1'b1;
    bit rx_gaps           = 1'b1;
    bit long_hold_pending = 1'b0;

    int unsigned items_sent       = 0;
    int unsigned samples_checked  = 0;
    int unsigned settings_applied = 0;
    int unsigned error_count      = 0;

    multi_waveform_oscillator u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_time_seconds (i_time_seconds),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sample       (o_sample),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin : quarter_sine_init
        logic [63:0] x;
        logic [63:0] sq;
        logic [63:0] acc;
        logic [63:0] coef [4];
        coef = '{PC7, PC5, PC3, PC1};
        for (int i = 0; i < QLEN; i++) begin
            x   = 64'(i) << (30 - SINE_TABLE_BITS);
            sq  = (x * x) >> 30;
            acc = PC9;
            foreach (coef[k]) begin
                acc = coef[k] - ((sq * acc) >> 30);
            end
            acc = (((x * acc) >> 30) + 64'd16384) >> 15;
            quarter_sine[i] = (acc > 64'd32767) ? 32767 : int'(acc);
        end
    end

    function automatic int sine_lookup(input logic [31:0] pos);
        int unsigned idx;
        idx = pos[29 -: SINE_TABLE_BITS];
        if (pos[30]) begin
            idx = (1 << SINE_TABLE_BITS) - idx;
        end
        return pos[31] ? -quarter_sine[idx] : quarter_sine[idx];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] predict_sample(
        input osc_settings_t cfg,
        input logic [TIME_W-1:0] stamp
    );
        logic [63:0] prod;
        logic [63:0] prod_n;
        logic [31:0] offset;
        logic [31:0] pos;
        logic [31:0] pos_n;
        longint      wave;
        longint      acc;
        longint      scaled;
        int unsigned lim;
        prod   = 64'(cfg.frequency_hz) * 64'(stamp);
        offset = {cfg.phase_offset, 16'h0000};
        pos    = prod[35:4] + offset;
        wave   = 0;
        case (cfg.waveform)
            WAVE_SINE: begin
                wave = sine_lookup(pos);
            end
            WAVE_SQUARE: begin
                wave = (sine_lookup(pos) > int'(cfg.shape_threshold)) ? FULL_SCALE : -FULL_SCALE;
            end
            WAVE_TRIANGLE: begin
                case (pos[31:30])
                    2'd0:    wave = longint'(pos[29:15]);
                    2'd1:    wave = FULL_SCALE - longint'(pos[29:15]);
                    2'd2:    wave = -longint'(pos[29:15]);
                    default: wave = longint'(pos[29:15]) - FULL_SCALE;
                endcase
            end
            WAVE_SAW: begin
                if (cfg.frequency_hz != '0) begin
                    wave = longint'(pos[31:16]) - FULL_SCALE;
                end
            end
            WAVE_INV_SAW: begin
                if (cfg.frequency_hz != '0) begin
                    wave = FULL_SCALE - longint'(pos[31:16]);
                end
            end
            WAVE_ADD_SAW: begin
                lim = (cfg.harmonic_limit > MAX_HARMONICS) ? MAX_HARMONICS : cfg.harmonic_limit;
                acc = 0;
                for (int unsigned n = 1; n < lim; n++) begin
                    prod_n = prod * 64'(n);
                    pos_n  = prod_n[35:4] + offset;
                    acc   += (longint'(sine_lookup(pos_n)) * FULL_SCALE) / longint'(n);
                end
                wave = ((acc >>> 15) * longint'(TWO_OVER_PI_Q30)) >>> 30;
            end
            default: begin
                wave = 0;
            end
        endcase
        scaled = (wave * longint'(cfg.volume)) >>> 7;
        if (scaled > SAMPLE_MAX) begin
            scaled = SAMPLE_MAX;
        end
        if (scaled < SAMPLE_MIN) begin
            scaled = SAMPLE_MIN;
        end
        return SAMPLE_W'(scaled);
    endfunction

    function automatic logic [TIME_W-1:0] random_stamp();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0:       return TIME_W'(r[23:0]);
            1:       return TIME_W'(r[31:0]);
            default: return r[TIME_W-1:0];
        endcase
    endfunction

    function automatic osc_settings_t random_settings();
        osc_settings_t cfg;
        if ($urandom_range(0, 9) == 0) begin
            cfg.waveform = 3'($urandom);
        end else begin
            cfg.waveform = 3'($urandom_range(WAVE_SINE, WAVE_ADD_SAW));
        end
        case ($urandom_range(0, 3))
            0:       cfg.volume = '1;
            1:       cfg.volume = 15'($urandom_range(0, 64));
            default: cfg.volume = 15'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       cfg.frequency_hz = '0;
            1:       cfg.frequency_hz = '1;
            2, 3:    cfg.frequency_hz = {12'($urandom_range(20, 4095)), 12'($urandom)};
            default: cfg.frequency_hz = 24'($urandom);
        endcase
        cfg.phase_offset = 16'($urandom);
        case ($urandom_range(0, 4))
            0:       cfg.shape_threshold = 16'sh8000;
            1:       cfg.shape_threshold = 16'sh7FFF;
            default: cfg.shape_threshold = 16'($urandom);
        endcase
        if ($urandom_range(0, 4) == 0) begin
            cfg.harmonic_limit = 6'($urandom);
        end else begin
            cfg.harmonic_limit = 6'($urandom_range(1, MAX_HARMONICS));
        end
        return cfg;
    endfunction

    task automatic send_time(input logic [TIME_W-1:0] stamp);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_time_seconds <= stamp;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_samples.push_back(predict_sample(settings, stamp));
        items_sent++;
    endtask

    task automatic drain_and_settle();
        i_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Bits above each register's width carry noise; the block must ignore them.
    task automatic reconfigure(input osc_settings_t cfg);
        logic [CFG_DATA_W-1:0] noise;
        drain_and_settle();
        noise = CFG_DATA_W'($urandom);
        put_reg(CFG_WAVEFORM,  {noise[23:3], cfg.waveform});
        put_reg(CFG_VOLUME,    {noise[23:15], cfg.volume});
        put_reg(CFG_FREQUENCY, cfg.frequency_hz);
        put_reg(CFG_PHASE,     {noise[23:16], cfg.phase_offset});
        put_reg(CFG_THRESHOLD, {noise[23:16], cfg.shape_threshold});
        put_reg(CFG_HARMONICS, {noise[23:6], cfg.harmonic_limit});
        i_cfg_we <= 1'b0;
        settings = cfg;
        settings_applied++;
    endtask

    task automatic test_reset_defaults();
        send_time('0);
        send_time('1);
    endtask

    task automatic test_each_waveform();
        logic [2:0]    codes [8];
        osc_settings_t cfg;
        codes = '{WAVE_SINE, WAVE_SQUARE, WAVE_TRIANGLE, WAVE_SAW,
                  WAVE_INV_SAW, WAVE_ADD_SAW, WAVE_SPARE_LO, WAVE_SPARE_HI};
        cfg                = RESET_SETTINGS;
        cfg.volume         = '1;
        cfg.frequency_hz   = '1;
        cfg.harmonic_limit = 6'(MAX_HARMONICS);
        foreach (codes[k]) begin
            cfg.waveform     = codes[k];
            cfg.phase_offset = 16'($urandom);
            reconfigure(cfg);
            send_time((k % 2 == 1) ? '1 : random_stamp());
        end
    endtask

    task automatic test_zero_frequency();
        osc_settings_t cfg;
        cfg              = RESET_SETTINGS;
        cfg.volume       = '1;
        cfg.frequency_hz = '0;
        cfg.phase_offset = 16'h2000;
        cfg.waveform     = WAVE_SAW;
        reconfigure(cfg);
        send_time(random_stamp());
        cfg.waveform = WAVE_INV_SAW;
        reconfigure(cfg);
        send_time(random_stamp());
        cfg.waveform = WAVE_ADD_SAW;
        reconfigure(cfg);
        send_time(random_stamp());
    endtask

    task automatic test_harmonic_bounds();
        logic [5:0]    limits [4];
        osc_settings_t cfg;
        limits           = '{6'd0, 6'd1, 6'(MAX_HARMONICS + 1), 6'h3F};
        cfg              = RESET_SETTINGS;
        cfg.waveform     = WAVE_ADD_SAW;
        cfg.volume       = '1;
        foreach (limits[k]) begin
            cfg.harmonic_limit = limits[k];
            reconfigure(cfg);
            send_time(random_stamp());
        end
        // At 1 Hz the overshoot next to the saw's edge drives the sample into saturation.
        cfg.frequency_hz   = 24'd4096;
        cfg.phase_offset   = '0;
        cfg.harmonic_limit = 6'(MAX_HARMONICS);
        reconfigure(cfg);
        send_time(TIME_W'(1) << 18);
        send_time((TIME_W'(1) << 24) - (TIME_W'(1) << 18));
    endtask

    task automatic test_square_threshold();
        osc_settings_t cfg;
        cfg                 = RESET_SETTINGS;
        cfg.waveform        = WAVE_SQUARE;
        cfg.shape_threshold = 16'sh8000;
        reconfigure(cfg);
        send_time(random_stamp());
        cfg.shape_threshold = 16'sh7FFF;
        reconfigure(cfg);
        send_time(random_stamp());
    endtask

    task automatic test_backpressure();
        osc_settings_t cfg;
        cfg          = random_settings();
        cfg.waveform = WAVE_ADD_SAW;
        reconfigure(cfg);
        tx_gaps           = 1'b0;
        long_hold_pending = 1'b1;
        repeat (24) send_time(random_stamp());
        drain_and_settle();
        tx_gaps = 1'b1;
    endtask

    task automatic test_random_phases(input int unsigned stop_at);
        while (items_sent < stop_at) begin
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            reconfigure(random_settings());
            repeat ($urandom_range(10, 40)) send_time(random_stamp());
        end
    endtask

    task automatic test_steady_tail(input int unsigned count);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        reconfigure(random_settings());
        repeat (count) send_time(random_stamp());
    endtask

    initial begin : sample_sink
        forever begin
            @(posedge i_clk);
            if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                i_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                i_ready <= 1'b1;
            end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : sample_check
        logic signed [SAMPLE_W-1:0] want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_samples.size() == 0) begin
                error_count++;
                $display("%0t: sample beat with none outstanding, expected none actual %0d",
                         $time, o_sample);
            end else begin
                want = expected_samples.pop_front();
                samples_checked++;
                if (o_sample !== want) begin
                    error_count++;
                    $display("%0t: sample mismatch, expected %0d actual %0d",
                             $time, want, o_sample);
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned stalled;
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                stalled = 0;
            end else begin
                stalled++;
            end
        end
        $display("%0t: no beat moved for %0d cycles, %0d samples outstanding",
                 $time, WATCHDOG_LIMIT, expected_samples.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_each_waveform();
        test_zero_frequency();
        test_harmonic_bounds();
        test_square_threshold();
        test_backpressure();
        test_random_phases(620);
        test_steady_tail(80);
        drain_and_settle();
        $display("Summary: %0d time stamps, %0d samples checked, %0d register settings.",
                 items_sent, samples_checked, settings_applied);
        $display("Covered all waveform codes, zero frequency, harmonic bounds, saturation, stalls.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
